>>> rtl/ssu_pkg.sv
// Package for the sorted set union block: payload types, sizes and codes.
// Used by every module of the block; depends on nothing.
package ssu_pkg;

	// Default number of distinct values the sorted store holds.
	localparam int SSU_CAPACITY = 32;

	// Default depth of the command queue between front and back.
	localparam int SSU_CMD_DEPTH = 4;

	// Element width.
	localparam int SSU_VALUE_W = 32;

	// Opcode values.
	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	// One input transaction.
	typedef struct packed {
		logic                          opcode;
		logic signed [SSU_VALUE_W-1:0] value;
	} ssu_in_t;

	// One result transaction.
	typedef struct packed {
		logic signed [SSU_VALUE_W-1:0] element;
		logic                          empty_set;
		logic                          overflowed;
		logic                          last_item;
	} ssu_out_t;

	// Command as classified by the front end.
	typedef struct packed {
		logic                          finish;
		logic signed [SSU_VALUE_W-1:0] value;
	} ssu_cmd_t;

	// Back-end sequencer states.
	typedef enum logic [1:0] {
		ST_RUN   = 2'b01,
		ST_DRAIN = 2'b10
	} ssu_state_t;

endpackage

>>> rtl/ssu_cmd_fifo.sv
// Front end of the sorted set union: classifies input transactions and
// queues them for the back end. Depends on ssu_pkg.
module ssu_cmd_fifo
	import ssu_pkg::*;
#(
	parameter int DEPTH = SSU_CMD_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  ssu_in_t  cmd,
	output logic     full,
	output logic     cmd_valid,
	output ssu_cmd_t cmd_head,
	input  logic     cmd_pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ssu_cmd_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   fill_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (fill_q == CW'(DEPTH));
	assign cmd_valid = (fill_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;
	assign cmd_head  = mem_q[rd_ptr_q];

	// Storage: classify the opcode on the way in.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q].finish <= (cmd.opcode == OP_FINISH);
			mem_q[wr_ptr_q].value  <= cmd.value;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/ssu_sort_core.sv
// Back end of the sorted set union: a chain of compare-and-shift cells that
// inserts one value per cycle while not draining and drains in ascending order. Depends on ssu_pkg.
module ssu_sort_core
	import ssu_pkg::*;
#(
	parameter int CAPACITY = SSU_CAPACITY
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	input  ssu_cmd_t cmd_head,
	output logic     cmd_pop,
	output logic     res_valid,
	output ssu_out_t res,
	input  logic     res_ready
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic signed [SSU_VALUE_W-1:0] store_q [CAPACITY];
	logic [CW-1:0]                 count_q;
	logic                          overflow_q;
	ssu_state_t                    state_q;

	logic [CAPACITY-1:0] lt;
	logic [CAPACITY-1:0] eq;
	logic                dup;
	logic                store_full;
	logic                do_insert;
	logic                do_shift;
	logic                is_add;
	logic                res_take;

	// Every cell compares its entry with the incoming value in parallel.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			lt[i] = (CW'(i) < count_q) && (store_q[i] < cmd_head.value);
			eq[i] = (CW'(i) < count_q) && (store_q[i] == cmd_head.value);
		end
	end

	assign dup        = |eq;
	assign store_full = (count_q == CW'(CAPACITY));
	assign is_add     = (state_q == ST_RUN) && cmd_valid && !cmd_head.finish;
	assign do_insert  = is_add && !dup && !store_full;
	assign res_take   = res_valid && res_ready;
	assign do_shift   = (state_q == ST_DRAIN) && res_ready;

	// While running, a queued add is always taken; a finish waits only when it must emit
	// the empty-set result at once.
	always_comb begin
		cmd_pop = 1'b0;
		if (state_q == ST_RUN && cmd_valid) begin
			if (!cmd_head.finish || count_q != '0) begin
				cmd_pop = 1'b1;
			end else begin
				cmd_pop = res_ready;
			end
		end
	end

	// Result offered to the output register.
	always_comb begin
		res_valid      = 1'b0;
		res.element    = store_q[0];
		res.empty_set  = 1'b0;
		res.overflowed = overflow_q;
		res.last_item  = (count_q == CW'(1));
		case (state_q)
			ST_RUN: begin
				if (cmd_valid && cmd_head.finish && count_q == '0) begin
					res_valid     = 1'b1;
					res.element   = '0;
					res.empty_set = 1'b1;
					res.last_item = 1'b1;
				end
			end
			ST_DRAIN: begin
				res_valid = 1'b1;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// Cell 0: takes the new value unless it stays below it; shifts up from cell 1.
	always_ff @(posedge clk) begin
		if (do_insert && !lt[0]) begin
			store_q[0] <= cmd_head.value;
		end else if (do_shift) begin
			store_q[0] <= (CAPACITY > 1) ? store_q[(CAPACITY > 1) ? 1 : 0] : store_q[0];
		end
	end

	// Remaining cells: keep, take the new value, take the lower neighbor on insert, or the upper one on drain.
	for (genvar g = 1; g < CAPACITY; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (do_insert && !lt[g]) begin
				store_q[g] <= lt[g-1] ? cmd_head.value : store_q[g-1];
			end else if (do_shift && g < CAPACITY - 1) begin
				store_q[g] <= store_q[(g < CAPACITY - 1) ? g + 1 : g];
			end
		end
	end

	// Sequencer, fill count and overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_RUN;
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (do_insert) begin
						count_q <= count_q + 1'b1;
					end else if (is_add && !dup && store_full) begin
						overflow_q <= 1'b1;
					end else if (cmd_valid && cmd_head.finish) begin
						if (count_q != '0) begin
							state_q <= ST_DRAIN;
						end else if (res_ready) begin
							overflow_q <= 1'b0;
						end
					end
				end
				ST_DRAIN: begin
					if (res_ready) begin
						count_q <= count_q - 1'b1;
						if (count_q == CW'(1)) begin
							state_q    <= ST_RUN;
							overflow_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	// The fill count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("store count above capacity");

	// Draining only happens while entries remain.
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (count_q != '0))
		else $error("drain with empty store");

	// The last result of a run leaves the store empty and the flag clear.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(res_take && res.last_item) |=>
			(state_q == ST_RUN && count_q == '0 && !overflow_q))
		else $error("store not cleared after last result");

endmodule

>>> rtl/sorted_set_union.sv
// Sorted set union: an add is inserted into the compare-and-shift cell chain.
// A finish emits N results, one per cycle while popped; the first passes the
// sequencer state, then the single output register (empty set: only the latter).
// Adds sustain one per cycle while not draining; the command queue decouples
// input from draining. Reset clears the queue, fill count, overflow flag and
// output valid flag; stored values stay undefined, never read before written.
module sorted_set_union
	import ssu_pkg::*;
#(
	parameter int CAPACITY  = SSU_CAPACITY,
	parameter int CMD_DEPTH = SSU_CMD_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  ssu_in_t  cmd,
	output logic     empty,
	input  logic     pop,
	output ssu_out_t result
);

	logic     cmd_valid;
	ssu_cmd_t cmd_head;
	logic     cmd_pop;
	logic     res_valid;
	ssu_out_t res;
	logic     res_ready;
	logic     out_valid_q;
	ssu_out_t out_q;

	// Front end: command queue.
	ssu_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.cmd       (cmd),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd_head  (cmd_head),
		.cmd_pop   (cmd_pop)
	);

	// Back end: sorted cell chain.
	ssu_sort_core #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_head  (cmd_head),
		.cmd_pop   (cmd_pop),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	// Output register: refilled in the same cycle its transaction is popped.
	assign res_ready = !out_valid_q || pop;
	assign empty     = !out_valid_q;
	assign result    = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

endmodule
